[rtl/wrms_pkg.sv]
// Package for the windowed RMS level meter: field widths, reset values and
// the request and status records passed between the top level and the root unit.
// Depends on nothing.
package wrms_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CNT_W        = 16;
    localparam int SUM_W        = 46;
    localparam int PROD_W       = 32;
    localparam int MEAN_W       = 32;
    localparam int ROOT_W       = 16;
    localparam int DIV_REM_W    = CNT_W;
    localparam int SQ_REM_W     = ROOT_W + 2;
    localparam int STEP_CNT_W   = 6;
    localparam int MUL_CNT_W    = 4;

    localparam logic [CNT_W-1:0]      WINDOW_RESET = CNT_W'(735);
    localparam logic [ROOT_W-1:0]     ROOT_MAX     = ROOT_W'(32768);
    localparam logic [STEP_CNT_W-1:0] DIV_LAST     = STEP_CNT_W'(SUM_W - 1);
    localparam logic [STEP_CNT_W-1:0] SQRT_LAST    = STEP_CNT_W'(MEAN_W / 2 - 1);
    localparam logic [MUL_CNT_W-1:0]  MUL_LAST     = MUL_CNT_W'(SAMPLE_W - 1);

    // Request from the accumulator to the mean and root unit.
    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     dividend;
        logic [CNT_W-1:0]     divisor;
    } wrms_req_t;

    // Status returned by the mean and root unit.
    typedef struct packed {
        logic                 done;
        logic [ROOT_W-1:0]    root;
    } wrms_stat_t;

endpackage

[rtl/windowed_rms_level_meter.sv]
// Top level of the windowed RMS level meter: serial squarer, window
// accumulator, output register. Uses wrms_pkg and wrms_mean_root.
//
// Channel        Direction  Handshake                                  Payload
// window_length  in         window_length_valid / window_length_ready  window_length[15:0]
// sample         in         sample_valid / sample_ready                sample[15:0] signed
// rms_level      out        rms_level_valid / rms_level_ready          rms_level[15:0]
//
// A sample is accepted in the idle state, squared in the shift-add squarer,
// then added into the window sum. A sample that closes the window then goes
// through the bit-serial divider and the square root before its level is handed over.
// Reset clears the window sum and count and sets window_length to 735.
// A level waiting in the output register does not stop the next samples; the
// block only stalls if a second level is ready before the first is taken.
module windowed_rms_level_meter
    import wrms_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       window_length_valid,
    output logic                       window_length_ready,
    input  logic [CNT_W-1:0]           window_length,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       rms_level_valid,
    input  logic                       rms_level_ready,
    output logic [ROOT_W-1:0]          rms_level
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_ACC  = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_OUT  = 5'b10000
    } top_state_t;

    top_state_t              state_reg, state_next;
    logic [MUL_CNT_W-1:0]    mul_cnt_reg, mul_cnt_next;
    logic [SAMPLE_W-1:0]     mag_reg, mag_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        window_reg;
    logic [ROOT_W-1:0]       hold_reg, hold_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ROOT_W-1:0]       out_level_reg, out_level_next;

    logic [SAMPLE_W-1:0]     sample_mag;
    logic [SAMPLE_W:0]       mul_add;
    logic [SUM_W-1:0]        sum_new;
    logic [CNT_W-1:0]        count_new;
    logic                    window_close;
    logic                    out_free;

    wrms_req_t               req;
    wrms_stat_t              stat;

    // Magnitude of the two's complement sample; full-scale negative gives 0x8000.
    assign sample_mag = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;

    // One shift-add step of the squarer, and the window update.
    always_comb
    begin
        mul_add      = {1'b0, prod_reg[PROD_W-1 -: SAMPLE_W]}
                       + (prod_reg[0] ? {1'b0, mag_reg} : '0);
        sum_new      = sum_reg + {{(SUM_W - PROD_W){1'b0}}, prod_reg};
        count_new    = count_reg + CNT_W'(1);
        window_close = (count_new >= window_reg);
        out_free     = !out_valid_reg || rms_level_ready;
    end

    assign req.start    = (state_reg == ST_ACC) && window_close;
    assign req.dividend = sum_new;
    assign req.divisor  = count_new;

    // Sample sequencer.
    always_comb
    begin
        state_next     = state_reg;
        mul_cnt_next   = mul_cnt_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && !rms_level_ready;
        out_level_next = out_level_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    mag_next     = sample_mag;
                    prod_next    = {{(PROD_W - SAMPLE_W){1'b0}}, sample_mag};
                    mul_cnt_next = MUL_LAST;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = {mul_add, prod_reg[SAMPLE_W-1:1]};
                if (mul_cnt_reg == '0)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    mul_cnt_next = mul_cnt_reg - MUL_CNT_W'(1);
                end
            end
            ST_ACC:
            begin
                if (window_close)
                begin
                    sum_next   = '0;
                    count_next = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    sum_next   = sum_new;
                    count_next = count_new;
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT:
            begin
                if (stat.done)
                begin
                    hold_next  = stat.root;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = hold_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_cnt_reg   <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            window_reg    <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_cnt_reg   <= mul_cnt_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (window_length_valid)
            begin
                window_reg <= window_length;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        prod_reg      <= prod_next;
        hold_reg      <= hold_next;
        out_level_reg <= out_level_next;
    end

    wrms_mean_root u_mean_root
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat)
    );

    assign window_length_ready = 1'b1;
    assign sample_ready        = (state_reg == ST_IDLE);
    assign rms_level_valid     = out_valid_reg;
    assign rms_level           = out_level_reg;

`ifndef SYNTHESIS
    // The root unit only reports back while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> state_reg == ST_ROOT)
        else $error("root result outside the wait state");

    // Closing a window clears the sum and the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> state_reg == ST_ROOT && sum_reg == '0 && count_reg == '0)
        else $error("window not cleared on close");

    // A delivered level never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_level_reg <= ROOT_MAX)
        else $error("level beyond full scale");
`endif

endmodule

[rtl/wrms_mean_root.sv]
// Mean and root unit: bit-serial restoring division of the window sum by the
// sample count, then a two-bit-per-step integer square root. Uses wrms_pkg.
module wrms_mean_root
    import wrms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  wrms_req_t  req,
    output wrms_stat_t stat
);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_DIV  = 4'b0010,
        U_SQRT = 4'b0100,
        U_DONE = 4'b1000
    } unit_state_t;

    unit_state_t               state_reg, state_next;
    logic [STEP_CNT_W-1:0]     step_reg, step_next;
    logic [SUM_W-1:0]          dq_reg, dq_next;
    logic [CNT_W-1:0]          divisor_reg, divisor_next;
    logic [DIV_REM_W-1:0]      div_rem_reg, div_rem_next;
    logic [MEAN_W-1:0]         rad_reg, rad_next;
    logic [SQ_REM_W-1:0]       sq_rem_reg, sq_rem_next;
    logic [ROOT_W-1:0]         root_reg, root_next;

    // One division step: shift the next dividend bit into the remainder.
    logic [DIV_REM_W:0]        div_shift;
    logic [DIV_REM_W:0]        div_diff;
    logic                      div_ge;

    // One root step: bring down two radicand bits and try the next root bit.
    logic [SQ_REM_W+1:0]       sq_shift;
    logic [SQ_REM_W+1:0]       sq_trial;
    logic [SQ_REM_W+1:0]       sq_diff;
    logic                      sq_ge;

    always_comb
    begin
        div_shift = {div_rem_reg, dq_reg[SUM_W-1]};
        div_diff  = div_shift - {1'b0, divisor_reg};
        div_ge    = (div_shift >= {1'b0, divisor_reg});

        sq_shift  = {sq_rem_reg, rad_reg[MEAN_W-1 -: 2]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        sq_diff   = sq_shift - sq_trial;
        sq_ge     = (sq_shift >= sq_trial);
    end

    // Sequencer for the two serial passes.
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        div_rem_next = div_rem_reg;
        rad_next     = rad_reg;
        sq_rem_next  = sq_rem_reg;
        root_next    = root_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    dq_next      = req.dividend;
                    divisor_next = req.divisor;
                    div_rem_next = '0;
                    step_next    = DIV_LAST;
                    state_next   = U_DIV;
                end
            end
            U_DIV:
            begin
                div_rem_next = div_ge ? div_diff[DIV_REM_W-1:0] : div_shift[DIV_REM_W-1:0];
                dq_next      = {dq_reg[SUM_W-2:0], div_ge};
                if (step_reg == '0)
                begin
                    rad_next    = dq_next[MEAN_W-1:0];
                    sq_rem_next = '0;
                    root_next   = '0;
                    step_next   = SQRT_LAST;
                    state_next  = U_SQRT;
                end
                else
                begin
                    step_next = step_reg - STEP_CNT_W'(1);
                end
            end
            U_SQRT:
            begin
                sq_rem_next = sq_ge ? sq_diff[SQ_REM_W-1:0] : sq_shift[SQ_REM_W-1:0];
                root_next   = {root_reg[ROOT_W-2:0], sq_ge};
                rad_next    = {rad_reg[MEAN_W-3:0], 2'b00};
                if (step_reg == '0)
                begin
                    state_next = U_DONE;
                end
                else
                begin
                    step_next = step_reg - STEP_CNT_W'(1);
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
        div_rem_reg <= div_rem_next;
        rad_reg     <= rad_next;
        sq_rem_reg  <= sq_rem_next;
        root_reg    <= root_next;
    end

    assign stat.done = (state_reg == U_DONE);
    assign stat.root = root_reg;

`ifndef SYNTHESIS
    // A new request only arrives while the unit is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == U_IDLE)
        else $error("root unit started while busy");

    // The mean never exceeds full scale squared, so the root stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> stat.root <= ROOT_MAX)
        else $error("root beyond full scale");

    // Division leaves a remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == U_SQRT && $past(state_reg) == U_DIV) |-> div_rem_reg < divisor_reg)
        else $error("division remainder out of range");
`endif

endmodule
